FILE: rtl/fcpa_pkg.sv
// ----------------------------------------------------------------------------
// fcpa_pkg
// Shared types and constants for the fixed chunk pool allocator.
// ----------------------------------------------------------------------------
package fcpa_pkg;

  // Payload widths fixed by the interface
  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 11;
  localparam int POOL_W   = 32;
  localparam int CHUNK_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Rounded chunk size (chunk size plus seven fits in 17 bits)
  localparam int CS_W     = CHUNK_W + 1;
  localparam int OFFSET_W = 33;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 16'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES  = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REBUILD = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_FREE    = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NONE_USED  = 2'd2,
    ST_STACK_FULL = 2'd3
  } status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, start stack read
    logic commit;  // update state, load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;  // result register holds a transfer not yet taken
  } stat_t;

endpackage

FILE: rtl/fcpa_in_if.sv
// ----------------------------------------------------------------------------
// fcpa_in_if
// Request channel: action and address being freed.
// ----------------------------------------------------------------------------
interface fcpa_in_if;
  import fcpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   free_address;

  modport source (output valid, output action, output free_address, input ready);
  modport sink   (input valid, input action, input free_address, output ready);
endinterface

FILE: rtl/fcpa_out_if.sv
// ----------------------------------------------------------------------------
// fcpa_out_if
// Result channel: status, granted address and chunks in use.
// ----------------------------------------------------------------------------
interface fcpa_out_if;
  import fcpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   chunk_address;
  logic [USED_W-1:0]   used_count;

  modport source (output valid, output status, output chunk_address, output used_count,
                  input ready);
  modport sink   (input valid, input status, input chunk_address, input used_count,
                  output ready);
endinterface

FILE: rtl/fcpa_cfg_if.sv
// ----------------------------------------------------------------------------
// fcpa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fcpa_cfg_if;
  import fcpa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/fcpa_ram.sv
// ----------------------------------------------------------------------------
// fcpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/fcpa_ctrl.sv
// ----------------------------------------------------------------------------
// fcpa_ctrl
// Two-state sequencer: capture a request, then commit it once the result
// register is free.
// ----------------------------------------------------------------------------
module fcpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  fcpa_pkg::stat_t stat,
  output fcpa_pkg::cmd_t  cmd
);
  import fcpa_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (req_valid) state_next = CS_EXEC;
      end
      CS_EXEC: begin
        if (!stat.out_busy) state_next = CS_IDLE;
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      CS_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      CS_EXEC: begin
        cmd.commit = !stat.out_busy;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // a captured request always moves to execute
  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == CS_EXEC)
    else $error("load not followed by execute");

  // commit returns to idle
  a_commit_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == CS_IDLE)
    else $error("commit not followed by idle");

  // never capture and commit together
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.commit))
    else $error("load and commit in the same cycle");

endmodule

FILE: rtl/fcpa_dp.sv
// ----------------------------------------------------------------------------
// fcpa_dp
// Allocator datapath: config registers, free stack, carve counters and the
// result register.
// ----------------------------------------------------------------------------
module fcpa_dp #(
  parameter int MAX_CHUNKS = 1024,
  parameter int ADDR_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // request payload
  input  logic [fcpa_pkg::ACTION_W-1:0]       req_action,
  input  logic [fcpa_pkg::ADDR_W-1:0]         req_free_address,
  // config write
  input  logic                                cfg_valid,
  input  logic [fcpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  // result
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic [fcpa_pkg::STATUS_W-1:0]       rsp_status,
  output logic [fcpa_pkg::ADDR_W-1:0]         rsp_chunk_address,
  output logic [fcpa_pkg::USED_W-1:0]         rsp_used_count,
  // control
  input  fcpa_pkg::cmd_t                      cmd,
  output fcpa_pkg::stat_t                     stat
);
  import fcpa_pkg::*;

  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam int AW = $clog2(MAX_CHUNKS);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CHUNKS);
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  // configuration
  logic [ADDR_W-1:0]  base_address;
  logic [POOL_W-1:0]  pool_bytes;
  logic [CHUNK_W-1:0] chunk_bytes;

  // allocator state
  logic [CW-1:0]       freed_depth;
  logic [OFFSET_W-1:0] carve_offset;
  logic [CW-1:0]       carved_total;
  logic [CW-1:0]       in_use;

  // captured request
  logic [ACTION_W-1:0] act_q;
  logic [ADDR_W-1:0]   faddr_q;

  // next values
  logic [CW-1:0]       freed_depth_next;
  logic [OFFSET_W-1:0] carve_offset_next;
  logic [CW-1:0]       carved_total_next;
  logic [CW-1:0]       in_use_next;
  status_t             status_next;
  logic [ADDR_W-1:0]   addr_next;

  // helpers
  logic [CHUNK_W-1:0]  chunk_eff;
  logic [CS_W-1:0]     chunk_rnd;
  logic [OFFSET_W:0]   carve_end;
  logic                carve_fits;
  logic [ADDR_W-1:0]   carve_addr;
  logic [CW-1:0]       depth_m1;
  logic                stack_full;
  logic                push_ok;
  logic [ADDR_W-1:0]   pop_data;
  logic [CW+USED_W-1:0] used_wide;

  // config writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      pool_bytes   <= '0;
      chunk_bytes  <= CHUNK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_ADDRESS: base_address <= cfg_data[ADDR_W-1:0];
        REG_POOL_BYTES:   pool_bytes   <= cfg_data[POOL_W-1:0];
        REG_CHUNK_BYTES:  chunk_bytes  <= cfg_data[CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q   <= req_action;
      faddr_q <= req_free_address;
    end
  end

  // chunk size rounded up to a multiple of 8, zero treated as 8
  assign chunk_eff  = (chunk_bytes == '0) ? CHUNK_RESET : chunk_bytes;
  assign chunk_rnd  = ({1'b0, chunk_eff} + CS_W'(7)) & ~CS_W'(7);
  assign carve_end  = {1'b0, carve_offset} + (OFFSET_W + 1)'(chunk_rnd);
  assign carve_fits = (carve_end <= (OFFSET_W + 1)'(pool_bytes)) && (carved_total < CNT_MAX);
  assign carve_addr = (base_address + carve_offset[ADDR_W-1:0]) & ADDR_MASK;

  assign depth_m1   = freed_depth - 1'b1;
  assign stack_full = (freed_depth == CNT_MAX);
  assign push_ok    = (act_q == ACT_FREE) && (in_use != '0) && !stack_full;

  // free stack: pop read starts at capture, push writes at commit
  fcpa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_CHUNKS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.commit && push_ok),
    .wr_addr (freed_depth[AW-1:0]),
    .wr_data (faddr_q),
    .rd_en   (cmd.load),
    .rd_addr (depth_m1[AW-1:0]),
    .rd_data (pop_data)
  );

  // item outcome
  always_comb begin
    freed_depth_next  = freed_depth;
    carve_offset_next = carve_offset;
    carved_total_next = carved_total;
    in_use_next       = in_use;
    status_next       = ST_OK;
    addr_next         = '0;
    case (act_q)
      ACT_REBUILD: begin
        freed_depth_next  = '0;
        carve_offset_next = '0;
        carved_total_next = '0;
        in_use_next       = '0;
      end
      ACT_ALLOC: begin
        if (freed_depth != '0) begin
          freed_depth_next = depth_m1;
          addr_next        = pop_data;
          in_use_next      = in_use + 1'b1;
        end else if (carve_fits) begin
          addr_next         = carve_addr;
          carve_offset_next = carve_end[OFFSET_W-1:0];
          carved_total_next = carved_total + 1'b1;
          in_use_next       = in_use + 1'b1;
        end else begin
          status_next = ST_EMPTY;
        end
      end
      ACT_FREE: begin
        if (in_use == '0) begin
          status_next = ST_NONE_USED;
        end else if (stack_full) begin
          status_next = ST_STACK_FULL;
        end else begin
          freed_depth_next = freed_depth + 1'b1;
          in_use_next      = in_use - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign used_wide = {{USED_W{1'b0}}, in_use_next};

  // allocator state update
  always_ff @(posedge clk) begin
    if (rst) begin
      freed_depth  <= '0;
      carve_offset <= '0;
      carved_total <= '0;
      in_use       <= '0;
    end else if (cmd.commit) begin
      freed_depth  <= freed_depth_next;
      carve_offset <= carve_offset_next;
      carved_total <= carved_total_next;
      in_use       <= in_use_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_status        <= status_next;
      rsp_chunk_address <= addr_next;
      rsp_used_count    <= used_wide[USED_W-1:0];
    end
  end

  assign stat.out_busy = rsp_valid && !rsp_ready;

  // every carved chunk is either in use or waiting on the free stack
  a_chunk_balance: assert property (@(posedge clk) disable iff (rst)
    (CW + 1)'(freed_depth) + (CW + 1)'(in_use) == (CW + 1)'(carved_total))
    else $error("carved chunks not balanced by in-use and freed");

  // a commit always presents a result next cycle
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("commit did not load the result register");

  // commit only when the result register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(rsp_valid && !rsp_ready))
    else $error("result overwritten before transfer");

endmodule

FILE: rtl/fixed_chunk_pool_allocator_core.sv
// Sequence: a request is captured in the idle state and committed in the execute
//   state, which loads the result register; no new request is taken until then.
// The free stack RAM read is issued at capture and its registered data is used
//   at commit. A stalled result register holds the commit.
// Reset (rst, synchronous): counters cleared, chunk size set to 8, config
//   cleared; free stack contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator_core
// Fixed-size chunk allocator with a LIFO free stack and a linear carve.
// ----------------------------------------------------------------------------
module fixed_chunk_pool_allocator_core #(
  parameter int MAX_CHUNKS = 1024,
  parameter int ADDR_BITS  = 32
) (
  input logic        clk,
  input logic        rst,
  fcpa_in_if.sink    req,
  fcpa_out_if.source rsp,
  fcpa_cfg_if.sink   cfg
);
  import fcpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // config writes always taken
  assign cfg.ready = 1'b1;

  fcpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fcpa_dp #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .req_action        (req.action),
    .req_free_address  (req.free_address),
    .cfg_valid         (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_chunk_address (rsp.chunk_address),
    .rsp_used_count    (rsp.used_count),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule
